### sv/ppt_pkg.sv
`timescale 1ns / 1ps

package ppt_pkg;

  // Field and coefficient widths.
  localparam int IO_W     = 24;
  localparam int COEF_W   = 20;
  localparam int ROW_W    = 3 * COEF_W;
  localparam int PROD_W   = COEF_W + IO_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int DIV_W    = SUM_W;
  localparam int QW       = IO_W;
  localparam int NUM_CELLS = QW;

  // The homogeneous constant 1 is 1 << ONE_SHIFT in Q16.8.
  localparam int ONE_SHIFT  = 8;
  localparam int HEAD_SHIFT = QW - ONE_SHIFT;

  // Stream payload widths.
  localparam int TDATA_W = 2 * IO_W;
  localparam int TUSER_W = 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_TOP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_MIDDLE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BOTTOM = CFG_IDX_W'(2);

  // Reset rows form the identity matrix (1.0 is 1 << 12 in Q8.12).
  localparam logic [ROW_W-1:0] ROW_TOP_RST    = ROW_W'(64'h0000_0000_0000_1000);
  localparam logic [ROW_W-1:0] ROW_MIDDLE_RST = ROW_W'(64'h0000_0001_0000_0000);
  localparam logic [ROW_W-1:0] ROW_BOTTOM_RST = ROW_W'(64'h0010_0000_0000_0000);

  // Output clipping limits.
  localparam logic [IO_W-1:0] OUT_MAX     = {1'b0, {(IO_W-1){1'b1}}};
  localparam logic [IO_W-1:0] OUT_MIN     = {1'b1, {(IO_W-1){1'b0}}};
  localparam logic [IO_W-1:0] NEG_MAG_MAX = {1'b1, {(IO_W-1){1'b0}}};

  // One lane of the divider: partial remainder, dividend bits still to
  // bring down, quotient bits so far, and the sideband for the final step.
  typedef struct packed {
    logic [QW-1:0]    n;
    logic [DIV_W-1:0] p;
    logic [QW-1:0]    q;
    logic             neg;
    logic             ovf;
  } lane_t;

  // What travels from cell to cell: both lanes share one divisor.
  typedef struct packed {
    lane_t            lx;
    lane_t            ly;
    logic [DIV_W-1:0] d;
    logic             dz;
  } cell_t;

  // Finished point.
  typedef struct packed {
    logic [IO_W-1:0] x;
    logic [IO_W-1:0] y;
    logic            dz;
    logic            sat;
  } result_t;

  typedef struct packed {
    logic [IO_W-1:0] val;
    logic            sat;
  } lane_res_t;

endpackage

### sv/projective_point_transform.sv
`timescale 1ns / 1ps

// Projective point transform: each input beat carries a Q16.8 point (x, y),
// which is multiplied as (x, y, 1) by the 3x3 Q8.12 matrix held in the three
// row registers; the output beat carries (u/w, v/w) in Q16.8, truncated
// toward zero and clipped, with a clip flag and a divide-by-zero flag (which
// forces a zero point). The block takes one point every clock cycle while
// the sink accepts results. Three stages form the products, the row sums and
// the operand magnitudes, a chain of 24 division cells produces one quotient
// bit each for both coordinates, and one output register holds the result.
// Rows reset to the identity matrix and should be written only while no
// point is in flight.
module projective_point_transform (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ppt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ppt_pkg::ROW_W-1:0]         cfg_data_i,
  // Input points.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ppt_pkg::TDATA_W-1:0]       s_axis_tdata,  // x_in, y_in
  // Output points.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ppt_pkg::TDATA_W-1:0]       m_axis_tdata,  // x_out, y_out
  output logic [ppt_pkg::TUSER_W-1:0]       m_axis_tuser   // div_by_zero, saturated
);

  // Matrix row registers.
  logic [ppt_pkg::ROW_W-1:0] row_top_q, row_middle_q, row_bottom_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_top_q    <= ppt_pkg::ROW_TOP_RST;
      row_middle_q <= ppt_pkg::ROW_MIDDLE_RST;
      row_bottom_q <= ppt_pkg::ROW_BOTTOM_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ppt_pkg::CFG_ROW_TOP:    row_top_q    <= cfg_data_i;
        ppt_pkg::CFG_ROW_MIDDLE: row_middle_q <= cfg_data_i;
        ppt_pkg::CFG_ROW_BOTTOM: row_bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Products, sums and divider operands.
  logic           chain_valid [ppt_pkg::NUM_CELLS+1];
  logic           chain_ready [ppt_pkg::NUM_CELLS+1];
  ppt_pkg::cell_t chain_cell  [ppt_pkg::NUM_CELLS+1];

  ppt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_top_i    (row_top_q),
    .row_middle_i (row_middle_q),
    .row_bottom_i (row_bottom_q),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .x_i          ($signed(s_axis_tdata[ppt_pkg::IO_W-1:0])),
    .y_i          ($signed(s_axis_tdata[ppt_pkg::TDATA_W-1:ppt_pkg::IO_W])),
    .valid_o      (chain_valid[0]),
    .ready_i      (chain_ready[0]),
    .cell_o       (chain_cell[0])
  );

  // Division chain, one quotient bit per cell.
  for (genvar k = 0; k < ppt_pkg::NUM_CELLS; k++) begin : g_cell
    ppt_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .cell_i  (chain_cell[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .cell_o  (chain_cell[k+1])
    );
  end

  // Sign, clipping and the output register.
  ppt_pkg::result_t res;

  ppt_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[ppt_pkg::NUM_CELLS]),
    .ready_o (chain_ready[ppt_pkg::NUM_CELLS]),
    .cell_i  (chain_cell[ppt_pkg::NUM_CELLS]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {res.y, res.x};
  assign m_axis_tuser = {res.sat, res.dz};

endmodule

### sv/ppt_front.sv
`timescale 1ns / 1ps

module ppt_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ppt_pkg::ROW_W-1:0]      row_top_i,
  input  logic [ppt_pkg::ROW_W-1:0]      row_middle_i,
  input  logic [ppt_pkg::ROW_W-1:0]      row_bottom_i,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [ppt_pkg::IO_W-1:0] x_i,
  input  logic signed [ppt_pkg::IO_W-1:0] y_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output ppt_pkg::cell_t                 cell_o
);

  logic [ppt_pkg::ROW_W-1:0] rows [3];
  logic signed [ppt_pkg::COEF_W-1:0] cf [3][3];

  assign rows[0] = row_top_i;
  assign rows[1] = row_middle_i;
  assign rows[2] = row_bottom_i;

  // Split each row into its three signed coefficients.
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign cf[r][c] = rows[r][c*ppt_pkg::COEF_W +: ppt_pkg::COEF_W];
    end
  end

  // Handshake of the three stages.
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready = !s3_valid_q || ready_i;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;
  assign valid_o  = s3_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  // Stage 1: the six coefficient products, one multiplier each.
  logic signed [ppt_pkg::PROD_W-1:0] s1_px_d [3];
  logic signed [ppt_pkg::PROD_W-1:0] s1_py_d [3];
  logic signed [ppt_pkg::PROD_W-1:0] s1_px_q [3];
  logic signed [ppt_pkg::PROD_W-1:0] s1_py_q [3];
  logic signed [ppt_pkg::COEF_W-1:0] s1_pc_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s1_px_d[r] = cf[r][0] * x_i;
      s1_py_d[r] = cf[r][1] * y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && s1_ready) begin
      for (int r = 0; r < 3; r++) begin
        s1_px_q[r] <= s1_px_d[r];
        s1_py_q[r] <= s1_py_d[r];
        s1_pc_q[r] <= cf[r][2];
      end
    end
  end

  // Stage 2: row sums u, v and w at 2^-20 scale.
  logic signed [ppt_pkg::SUM_W-1:0] s2_sum_d [3];
  logic signed [ppt_pkg::SUM_W-1:0] s2_sum_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s2_sum_d[r] = ppt_pkg::SUM_W'(s1_px_q[r]) + ppt_pkg::SUM_W'(s1_py_q[r])
                  + (ppt_pkg::SUM_W'(s1_pc_q[r]) <<< ppt_pkg::ONE_SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      for (int r = 0; r < 3; r++) begin
        s2_sum_q[r] <= s2_sum_d[r];
      end
    end
  end

  // Stage 3: magnitudes, result signs and the overflow test on the
  // high dividend bits, which leaves 24 quotient bits for the cells.
  function automatic logic [ppt_pkg::SUM_W-1:0] abs_val(
    input logic [ppt_pkg::SUM_W-1:0] v
  );
    abs_val = v[ppt_pkg::SUM_W-1] ? (~v + ppt_pkg::SUM_W'(1)) : v;
  endfunction

  function automatic ppt_pkg::lane_t prep_lane(
    input logic [ppt_pkg::SUM_W-1:0] num,
    input logic                      w_neg,
    input logic [ppt_pkg::DIV_W-1:0] den
  );
    ppt_pkg::lane_t              l;
    logic [ppt_pkg::SUM_W-1:0]   mag;
    logic [ppt_pkg::DIV_W-1:0]   head;
    mag    = abs_val(num);
    head   = ppt_pkg::DIV_W'(mag >> ppt_pkg::HEAD_SHIFT);
    l.p    = head;
    l.n    = {mag[ppt_pkg::HEAD_SHIFT-1:0], {ppt_pkg::ONE_SHIFT{1'b0}}};
    l.q    = '0;
    l.neg  = num[ppt_pkg::SUM_W-1] ^ w_neg;
    l.ovf  = head >= den;
    prep_lane = l;
  endfunction

  ppt_pkg::cell_t s3_d;

  always_comb begin
    s3_d.d  = ppt_pkg::DIV_W'(abs_val(s2_sum_q[2]));
    s3_d.dz = (s2_sum_q[2] == '0);
    s3_d.lx = prep_lane(s2_sum_q[0], s2_sum_q[2][ppt_pkg::SUM_W-1], s3_d.d);
    s3_d.ly = prep_lane(s2_sum_q[1], s2_sum_q[2][ppt_pkg::SUM_W-1], s3_d.d);
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s3_ready) begin
      cell_o <= s3_d;
    end
  end

endmodule

### sv/ppt_div_cell.sv
`timescale 1ns / 1ps

module ppt_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  ppt_pkg::cell_t cell_i,
  output logic           valid_o,
  input  logic           ready_i,
  output ppt_pkg::cell_t cell_o
);

  // One restoring division step: bring down the next dividend bit, try to
  // subtract the divisor, and shift the outcome into the quotient.
  function automatic ppt_pkg::lane_t step(
    input ppt_pkg::lane_t            l,
    input logic [ppt_pkg::DIV_W-1:0] den
  );
    ppt_pkg::lane_t            r;
    logic [ppt_pkg::DIV_W:0]   t;
    logic [ppt_pkg::DIV_W:0]   dd;
    logic [ppt_pkg::DIV_W:0]   diff;
    logic                      ge;
    t     = {l.p, l.n[ppt_pkg::QW-1]};
    dd    = {1'b0, den};
    diff  = t - dd;
    ge    = t >= dd;
    r.p   = ge ? diff[ppt_pkg::DIV_W-1:0] : t[ppt_pkg::DIV_W-1:0];
    r.n   = {l.n[ppt_pkg::QW-2:0], 1'b0};
    r.q   = {l.q[ppt_pkg::QW-2:0], ge};
    r.neg = l.neg;
    r.ovf = l.ovf;
    step  = r;
  endfunction

  logic           valid_q;
  ppt_pkg::cell_t cell_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_comb begin
    cell_d    = cell_i;
    cell_d.lx = step(cell_i.lx, cell_i.d);
    cell_d.ly = step(cell_i.ly, cell_i.d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      cell_o <= cell_d;
    end
  end

endmodule

### sv/ppt_finish.sv
`timescale 1ns / 1ps

module ppt_finish (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  ppt_pkg::cell_t   cell_i,
  output logic             valid_o,
  input  logic             ready_i,
  output ppt_pkg::result_t res_o
);

  // Apply the sign to the quotient magnitude and clip to Q16.8.
  function automatic ppt_pkg::lane_res_t finish_lane(input ppt_pkg::lane_t l);
    ppt_pkg::lane_res_t r;
    r.sat = 1'b0;
    if (l.ovf) begin
      r.sat = 1'b1;
      r.val = l.neg ? ppt_pkg::OUT_MIN : ppt_pkg::OUT_MAX;
    end else if (l.neg) begin
      if (l.q > ppt_pkg::NEG_MAG_MAX) begin
        r.sat = 1'b1;
        r.val = ppt_pkg::OUT_MIN;
      end else begin
        r.val = ~l.q + ppt_pkg::IO_W'(1);
      end
    end else begin
      if (l.q > ppt_pkg::OUT_MAX) begin
        r.sat = 1'b1;
        r.val = ppt_pkg::OUT_MAX;
      end else begin
        r.val = l.q;
      end
    end
    finish_lane = r;
  endfunction

  ppt_pkg::lane_res_t rx, ry;
  ppt_pkg::result_t   res_d;
  logic               valid_q;

  // A zero divisor forces a zero point and clears the clip flag.
  always_comb begin
    rx = finish_lane(cell_i.lx);
    ry = finish_lane(cell_i.ly);
    if (cell_i.dz) begin
      res_d.x   = '0;
      res_d.y   = '0;
      res_d.dz  = 1'b1;
      res_d.sat = 1'b0;
    end else begin
      res_d.x   = rx.val;
      res_d.y   = ry.val;
      res_d.dz  = 1'b0;
      res_d.sat = rx.sat | ry.sat;
    end
  end

  // Output register; it holds a beat until the sink takes it.
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_o <= res_d;
    end
  end

endmodule

### tb/projective_point_transform_tb.sv
`timescale 1ns / 1ps

module projective_point_transform_tb;
  import ppt_pkg::*;

  localparam int LATENCY_PAD     = 40;
  localparam int HOLD_CYCLES     = 300;
  localparam int NUM_PHASES      = 8;
  localparam int POINTS_PER_PHASE = 55;

  localparam logic [COEF_W-1:0] COEF_MAX = 20'h7FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 20'h80000;
  localparam logic [COEF_W-1:0] COEF_ONE = 20'h01000;
  localparam logic [IO_W-1:0]   COORD_MAX = 24'h7FFFFF;
  localparam logic [IO_W-1:0]   COORD_MIN = 24'h800000;

  // Indexes that map to no row register.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST  = '1;

  localparam longint Q_HI = (longint'(1) << (IO_W - 1)) - 1;
  localparam longint Q_LO = -(longint'(1) << (IO_W - 1));

  // Tracks the matrix and the transformed points still owed by the block.
  class point_scoreboard;
    logic [ROW_W-1:0] rows [3];
    result_t          owed_points [$];
    int               errors;

    function new();
      rows[0] = ROW_TOP_RST;
      rows[1] = ROW_MIDDLE_RST;
      rows[2] = ROW_BOTTOM_RST;
      errors  = 0;
    endfunction

    function void set_row(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
      case (idx)
        CFG_ROW_TOP:    rows[0] = val;
        CFG_ROW_MIDDLE: rows[1] = val;
        CFG_ROW_BOTTOM: rows[2] = val;
        default: ;
      endcase
    endfunction

    function longint coef_at(logic [ROW_W-1:0] r, int col);
      logic signed [COEF_W-1:0] c;
      c = r[col*COEF_W +: COEF_W];
      return longint'(c);
    endfunction

    // Dot product of one row with (x, y, 1), exact at 2^-20 scale.
    function longint row_sum(logic [ROW_W-1:0] r, longint x, longint y);
      return coef_at(r, 0) * x + coef_at(r, 1) * y
             + coef_at(r, 2) * (longint'(1) << ONE_SHIFT);
    endfunction

    // Quotient truncated toward zero, then clipped to the Q16.8 range.
    function logic [IO_W-1:0] clip_quot(longint num, longint den, inout bit sat);
      longint q;
      q = (num * (longint'(1) << ONE_SHIFT)) / den;
      if (q > Q_HI) begin
        sat = 1'b1;
        q = Q_HI;
      end else if (q < Q_LO) begin
        sat = 1'b1;
        q = Q_LO;
      end
      return q[IO_W-1:0];
    endfunction

    function void note_point(logic [TDATA_W-1:0] d);
      logic signed [IO_W-1:0] xs, ys;
      longint x, y, u, v, w;
      bit sat;
      result_t r;
      xs = d[IO_W-1:0];
      ys = d[TDATA_W-1:IO_W];
      x = xs;
      y = ys;
      u = row_sum(rows[0], x, y);
      v = row_sum(rows[1], x, y);
      w = row_sum(rows[2], x, y);
      r = '0;
      sat = 1'b0;
      if (w == 0) begin
        r.dz = 1'b1;
      end else begin
        r.x = clip_quot(u, w, sat);
        r.y = clip_quot(v, w, sat);
        r.sat = sat;
      end
      owed_points.push_back(r);
    endfunction

    function void check_point(logic [TDATA_W-1:0] d, logic [TUSER_W-1:0] u);
      result_t e;
      if (owed_points.size() == 0) begin
        $display("%0t: unexpected output beat, tdata %h tuser %b", $time, d, u);
        errors++;
        return;
      end
      e = owed_points.pop_front();
      if (d[IO_W-1:0] !== e.x) begin
        $display("%0t: x_out expected %h, got %h", $time, e.x, d[IO_W-1:0]);
        errors++;
      end
      if (d[TDATA_W-1:IO_W] !== e.y) begin
        $display("%0t: y_out expected %h, got %h", $time, e.y, d[TDATA_W-1:IO_W]);
        errors++;
      end
      if (u[0] !== e.dz) begin
        $display("%0t: div_by_zero expected %b, got %b", $time, e.dz, u[0]);
        errors++;
      end
      if (u[1] !== e.sat) begin
        $display("%0t: saturated expected %b, got %b", $time, e.sat, u[1]);
        errors++;
      end
    endfunction

    function int pending();
      return owed_points.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [ROW_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic [TUSER_W-1:0]   m_axis_tuser;

  bit sender_gapless = 1'b0;
  bit sink_gapless   = 1'b0;
  bit sink_hold_req  = 1'b0;

  point_scoreboard sb = new();

  projective_point_transform dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Both stream monitors sample the values that were present before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_point(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_point(m_axis_tdata, m_axis_tuser);
    end
  end

  // Half the time no gap, else mostly a short one, now and then a long one.
  function automatic int pick_gap(bit gapless);
    int r;
    r = $urandom_range(0, 99);
    if (gapless || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(logic [COEF_W-1:0] c0,
                                                logic [COEF_W-1:0] c1,
                                                logic [COEF_W-1:0] c2);
    return {c2, c1, c0};
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COEF_MAX;
      2:       return COEF_MIN;
      3, 4, 5: return COEF_W'($urandom_range(0, 16384) - 8192);
      6, 7:    return COEF_ONE + COEF_W'($urandom_range(0, 512)) - COEF_W'(256);
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    return pack_row(rand_coef(), rand_coef(), rand_coef());
  endfunction

  function automatic logic [IO_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return IO_W'($urandom);
      4, 5, 6:    return IO_W'($urandom_range(0, 8192) - 4096);
      7: begin
        case ($urandom_range(0, 3))
          0:       return COORD_MAX;
          1:       return COORD_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default:    return IO_W'($urandom_range(0, 131072) - 65536);
    endcase
  endfunction

  // Valid stays high across back-to-back register beats.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val, bit last);
    if (!cfg_valid_i) cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_row(idx, val);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic write_matrix(logic [ROW_W-1:0] top, logic [ROW_W-1:0] mid,
                              logic [ROW_W-1:0] bot);
    cfg_write(CFG_ROW_TOP, top, 1'b0);
    cfg_write(CFG_ROW_MIDDLE, mid, 1'b0);
    cfg_write(CFG_ROW_BOTTOM, bot, 1'b1);
  endtask

  task automatic send_point(logic [IO_W-1:0] x, logic [IO_W-1:0] y);
    int gap;
    if (!s_axis_tvalid) s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    gap = pick_gap(sender_gapless);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering points, waits until every owed point has come back, then
  // lets the pipe settle.
  task automatic wait_idle();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY_PAD) @(posedge clk_i);
  endtask

  // Output side: random ready pattern, plus one long hold on request.
  initial begin : sink
    int run_len, stall_len;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      run_len = $urandom_range(1, 16);
      m_axis_tready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      stall_len = pick_gap(sink_gapless);
      if (stall_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [ROW_W-1:0] top, mid, bot;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Identity matrix after reset: extremes of both coordinates.
    send_point('0, '0);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN);
    send_point('1, 24'h000001);
    send_point(24'h000100, 24'hFFFF00);
    wait_idle();

    // Writes to unmapped indexes must leave the identity in place.
    cfg_write(CFG_IDX_SPARE, '1, 1'b0);
    cfg_write(CFG_IDX_LAST, '0, 1'b1);
    send_point(24'h003039, 24'hFF2C4F);
    send_point(COORD_MIN, COORD_MAX);
    wait_idle();

    // Extreme coefficients scale x by nearly 128 and y by -128, clipping large inputs.
    write_matrix(pack_row(COEF_MAX, '0, '0), pack_row('0, COEF_MIN, '0), ROW_BOTTOM_RST);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN);
    send_point(24'h000001, 24'h000001);
    send_point(24'h000100, 24'hFFFF00);
    wait_idle();

    // Divisor follows x: zero at x = 0, negative for negative x, tiny near 0.
    write_matrix(ROW_TOP_RST, ROW_MIDDLE_RST, pack_row(COEF_ONE, '0, '0));
    send_point('0, 24'h000500);
    send_point(24'hFFFF00, 24'h000100);
    send_point(COORD_MIN, COORD_MAX);
    send_point(24'h000001, COORD_MAX);
    wait_idle();

    // All-zero matrix: every point divides by zero.
    write_matrix('0, '0, '0);
    send_point(24'h123456, 24'hABCDEF);
    wait_idle();

    // Random points under a series of matrices, extremes first.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          top = '1;
          mid = '1;
          bot = '1;
        end
        1: begin
          top = pack_row(COEF_MAX, COEF_MAX, COEF_MAX);
          mid = top;
          bot = top;
        end
        2: begin
          top = pack_row(COEF_MIN, COEF_MIN, COEF_MIN);
          mid = top;
          bot = rand_row();
        end
        default: begin
          top = rand_row();
          mid = rand_row();
          bot = rand_row();
        end
      endcase
      write_matrix(top, mid, bot);
      sender_gapless = (p == 3 || p == 5);
      sink_gapless   = (p == 5);
      if (p == 3) sink_hold_req = 1'b1;
      for (int i = 0; i < POINTS_PER_PHASE; i++) send_point(rand_coord(), rand_coord());
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
